### design/rmqc_pkg.sv
package rmqc_pkg;

	localparam int DATA_WIDTH = 16;

	// Branch taken by the matrix to quaternion path; the code is also the
	// slot of the component formed from the square root.
	typedef enum logic [1:0] {
		BR_TRACE,
		BR_X,
		BR_Y,
		BR_Z
	} br_t;

	typedef struct packed {
		logic                         func;
		logic signed [DATA_WIDTH-1:0] elem_0;
		logic signed [DATA_WIDTH-1:0] elem_1;
		logic signed [DATA_WIDTH-1:0] elem_2;
		logic signed [DATA_WIDTH-1:0] elem_3;
		logic signed [DATA_WIDTH-1:0] elem_4;
		logic signed [DATA_WIDTH-1:0] elem_5;
		logic signed [DATA_WIDTH-1:0] elem_6;
		logic signed [DATA_WIDTH-1:0] elem_7;
		logic signed [DATA_WIDTH-1:0] elem_8;
	} item_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] out_0;
		logic signed [DATA_WIDTH-1:0] out_1;
		logic signed [DATA_WIDTH-1:0] out_2;
		logic signed [DATA_WIDTH-1:0] out_3;
		logic signed [DATA_WIDTH-1:0] out_4;
		logic signed [DATA_WIDTH-1:0] out_5;
		logic signed [DATA_WIDTH-1:0] out_6;
		logic signed [DATA_WIDTH-1:0] out_7;
		logic signed [DATA_WIDTH-1:0] out_8;
	} result_t;

endpackage

### design/rotation_matrix_quaternion_convert.sv
// Rotation matrix <-> quaternion converter, signed fixed point with FRAC_BITS fraction
// bits in 16-bit words. A word with func 0 takes a 3x3 matrix (row major) and returns
// w, x, y, z by Shepperd's method: the trace branch when the trace is positive, else
// the branch of the largest diagonal element; out_4..out_8 are zero. A word with func 1
// takes w, x, y, z in elem_0..elem_3 and returns the rotation matrix. Results saturate;
// the quaternion is neither normalised nor sign-fixed, and a negative radicand counts as
// zero (a zero root gives zero components). The block is a flat pipeline that takes one
// word every cycle while item_stall is low. The number of root bits is RB = ceil((FRAC_BITS
// + max(18, FRAC_BITS + 1) + 1) / 2). The length is set by the square root, one root bit
// per stage, followed by three parallel dividers, one quotient bit per stage over 17
// stages. Each stage holds its word while the next is full and blocked, so bubbles close
// up and the input keeps flowing while a finished result waits on result_stall, until
// the pipeline is full.
module rotation_matrix_quaternion_convert
	import rmqc_pkg::*;
#(
	parameter int FRAC_BITS = 14
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int W   = DATA_WIDTH;
	localparam int RW  = ((W + 2 > FRAC_BITS + 1) ? W + 2 : FRAC_BITS + 1) + 2;
	localparam int SW  = RW - 1 + FRAC_BITS;
	localparam int SW2 = SW + (SW % 2);
	localparam int RB  = SW2 / 2;
	localparam int QB  = W + 1;
	localparam int NW  = ((W + 1 + FRAC_BITS > RB) ? W + 1 + FRAC_BITS : RB) + 1;
	localparam int CW  = ((NW > RB + 1 + QB) ? NW : RB + 1 + QB) + 1;
	localparam int PW  = 2 * W + 1;
	localparam int TW  = ((PW + 1 > FRAC_BITS + 2) ? PW + 1 : FRAC_BITS + 2) + 1;
	localparam int NP  = RB + QB + 4;

	localparam logic [RW-1:0] ONE_R = RW'(1) << FRAC_BITS;
	localparam logic [TW-1:0] ONE_T = TW'(1) << FRAC_BITS;
	localparam logic signed [63:0] MAXV = (64'sd1 <<< (W - 1)) - 64'sd1;
	localparam logic signed [63:0] MINV = -MAXV - 64'sd1;

	typedef struct packed {
		logic                     func;
		br_t                      br;
		logic [SW2-1:0]           rad;
		logic [RB+1:0]            rem;
		logic [RB-1:0]            root;
		logic [2:0][W:0]          num;
		logic [8:0][2*W-1:0]      prod;
		logic [8:0][W-1:0]        mat;
		logic                     zr;
		logic [RB:0]              dvs;
		logic [2:0][NW-1:0]       dr;
		logic [2:0][QB-1:0]       q;
		logic [2:0]               ovf;
		logic [2:0]               neg;
		logic [8:0][W-1:0]        res;
	} pipe_t;

	function automatic logic [W-1:0] sat(input logic signed [63:0] v);
		if (v > MAXV)
			sat = W'(MAXV);
		else if (v < MINV)
			sat = W'(MINV);
		else
			sat = W'(v);
	endfunction

	// 2*s reduced to the fraction width, nearest with ties away from zero
	function automatic logic signed [TW-1:0] twice(input logic signed [PW-1:0] s);
		logic [PW-1:0] mag;
		logic [PW:0]   acc;
		mag = s[PW-1] ? PW'(-s) : PW'(s);
		acc = (PW+1)'(mag) + ((PW+1)'(1) << (FRAC_BITS - 2));
		acc = acc >> (FRAC_BITS - 1);
		twice = s[PW-1] ? -$signed(TW'(acc)) : $signed(TW'(acc));
	endfunction

	function automatic logic signed [PW-1:0] wide(input logic [2*W-1:0] p);
		wide = PW'($signed(p));
	endfunction

	// Input register
	item_t       in_s1;
	logic        vld_s1;
	logic        adv_s1;
	pipe_t       pipe_sn [NP];
	logic [NP-1:0] vld_sn;
	logic [NP-1:0] adv;

	assign adv_s1     = !vld_s1 || adv[0];
	assign item_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && item_valid) begin
			in_s1 <= item;
		end
	end

	// A stage advances when it is empty or the one after it advances
	always_comb begin
		for (int k = 0; k < NP - 1; k++) begin
			adv[k] = !vld_sn[k] || adv[k+1];
		end
		adv[NP-1] = !vld_sn[NP-1] || !result_stall;
	end

	for (genvar k = 0; k < NP; k++) begin : g_stage
		pipe_t nxt;
		logic  src_vld;

		if (k == 0) begin : g_prep
			logic signed [W-1:0] e [9];
			logic signed [W+1:0] trace;
			logic signed [RW-1:0] radv;
			logic [RW-2:0]       radc;

			assign src_vld = vld_s1;

			// Trace, branch choice, radicand, numerators and the nine products
			always_comb begin
				e[0] = in_s1.elem_0;
				e[1] = in_s1.elem_1;
				e[2] = in_s1.elem_2;
				e[3] = in_s1.elem_3;
				e[4] = in_s1.elem_4;
				e[5] = in_s1.elem_5;
				e[6] = in_s1.elem_6;
				e[7] = in_s1.elem_7;
				e[8] = in_s1.elem_8;
				nxt = '0;
				nxt.func = in_s1.func;
				trace = (W+2)'(e[0]) + (W+2)'(e[4]) + (W+2)'(e[8]);
				if (trace > 0) begin
					nxt.br = BR_TRACE;
					radv = $signed(ONE_R) + RW'(trace);
					nxt.num[0] = (W+1)'(e[7]) - (W+1)'(e[5]);
					nxt.num[1] = (W+1)'(e[2]) - (W+1)'(e[6]);
					nxt.num[2] = (W+1)'(e[3]) - (W+1)'(e[1]);
				end else if (e[0] > e[4] && e[0] > e[8]) begin
					nxt.br = BR_X;
					radv = $signed(ONE_R) + RW'(e[0]) - RW'(e[4]) - RW'(e[8]);
					nxt.num[0] = (W+1)'(e[7]) - (W+1)'(e[5]);
					nxt.num[1] = (W+1)'(e[1]) + (W+1)'(e[3]);
					nxt.num[2] = (W+1)'(e[2]) + (W+1)'(e[6]);
				end else if (e[4] > e[8]) begin
					nxt.br = BR_Y;
					radv = $signed(ONE_R) + RW'(e[4]) - RW'(e[0]) - RW'(e[8]);
					nxt.num[0] = (W+1)'(e[2]) - (W+1)'(e[6]);
					nxt.num[1] = (W+1)'(e[1]) + (W+1)'(e[3]);
					nxt.num[2] = (W+1)'(e[5]) + (W+1)'(e[7]);
				end else begin
					nxt.br = BR_Z;
					radv = $signed(ONE_R) + RW'(e[8]) - RW'(e[0]) - RW'(e[4]);
					nxt.num[0] = (W+1)'(e[3]) - (W+1)'(e[1]);
					nxt.num[1] = (W+1)'(e[2]) + (W+1)'(e[6]);
					nxt.num[2] = (W+1)'(e[5]) + (W+1)'(e[7]);
				end
				radc = radv[RW-1] ? '0 : radv[RW-2:0];
				nxt.rad = SW2'(radc) << FRAC_BITS;
				// w = e0, x = e1, y = e2, z = e3
				nxt.prod[0] = e[1] * e[1];
				nxt.prod[1] = e[2] * e[2];
				nxt.prod[2] = e[3] * e[3];
				nxt.prod[3] = e[1] * e[2];
				nxt.prod[4] = e[1] * e[3];
				nxt.prod[5] = e[2] * e[3];
				nxt.prod[6] = e[1] * e[0];
				nxt.prod[7] = e[2] * e[0];
				nxt.prod[8] = e[3] * e[0];
			end
		end else begin : g_work
			pipe_t p;

			assign src_vld = vld_sn[k-1];
			assign p       = pipe_sn[k-1];

			if (k == 1) begin : g_mat
				// Quadratic matrix formula from the registered products
				always_comb begin
					nxt = p;
					nxt.mat[0] = sat(64'($signed(ONE_T)
						- twice(wide(p.prod[1]) + wide(p.prod[2]))));
					nxt.mat[1] = sat(64'(twice(wide(p.prod[3]) - wide(p.prod[8]))));
					nxt.mat[2] = sat(64'(twice(wide(p.prod[4]) + wide(p.prod[7]))));
					nxt.mat[3] = sat(64'(twice(wide(p.prod[3]) + wide(p.prod[8]))));
					nxt.mat[4] = sat(64'($signed(ONE_T)
						- twice(wide(p.prod[0]) + wide(p.prod[2]))));
					nxt.mat[5] = sat(64'(twice(wide(p.prod[5]) - wide(p.prod[6]))));
					nxt.mat[6] = sat(64'(twice(wide(p.prod[4]) - wide(p.prod[7]))));
					nxt.mat[7] = sat(64'(twice(wide(p.prod[5]) + wide(p.prod[6]))));
					nxt.mat[8] = sat(64'($signed(ONE_T)
						- twice(wide(p.prod[0]) + wide(p.prod[1]))));
					nxt.rem  = '0;
					nxt.root = '0;
				end
			end else if (k < RB + 2) begin : g_sqrt
				logic [RB+3:0] cur;
				logic [RB+3:0] trial;

				// One root bit: bring down two radicand bits, try root*4+1
				always_comb begin
					nxt   = p;
					cur   = {p.rem, p.rad[SW2-1 -: 2]};
					trial = {2'b00, p.root, 2'b01};
					if (cur >= trial) begin
						nxt.rem  = (RB+2)'(cur - trial);
						nxt.root = {p.root[RB-2:0], 1'b1};
					end else begin
						nxt.rem  = cur[RB+1:0];
						nxt.root = {p.root[RB-2:0], 1'b0};
					end
					nxt.rad = p.rad << 2;
				end
			end else if (k == RB + 2) begin : g_dset
				logic [W:0]    mag;
				logic [NW-1:0] n;

				// Dividend (|num| << F) + root, divisor 2*root; flag quotients
				// that will not fit
				always_comb begin
					nxt     = p;
					nxt.zr  = (p.root == '0);
					nxt.dvs = {p.root, 1'b0};
					nxt.q   = '0;
					mag     = '0;
					n       = '0;
					for (int j = 0; j < 3; j++) begin
						nxt.neg[j] = p.num[j][W];
						mag = p.num[j][W] ? (W+1)'(-$signed(p.num[j])) : p.num[j];
						n = (NW'(mag) << FRAC_BITS) + NW'(p.root);
						nxt.dr[j]  = n;
						nxt.ovf[j] = CW'(n) >= (CW'({p.root, 1'b0}) << QB);
					end
				end
			end else if (k < NP - 1) begin : g_div
				localparam int BIT = QB - 1 - (k - RB - 3);
				logic [CW-1:0] t;

				// One quotient bit for each of the three dividers
				always_comb begin
					nxt = p;
					t   = CW'(p.dvs) << BIT;
					for (int j = 0; j < 3; j++) begin
						if (CW'(p.dr[j]) >= t) begin
							nxt.dr[j]     = NW'(CW'(p.dr[j]) - t);
							nxt.q[j][BIT] = 1'b1;
						end
					end
				end
			end else begin : g_out
				logic [W-1:0]         dv [3];
				logic [W-1:0]         half;
				logic signed [63:0]   qs;
				int                   idx;

				// Sign and saturate quotients, then place them around the
				// component taken from the root
				always_comb begin
					nxt  = p;
					half = sat(64'((RB+1)'(p.root) + (RB+1)'(1)) >>> 1);
					qs   = '0;
					idx  = 0;
					for (int j = 0; j < 3; j++) begin
						qs = $signed(64'(p.q[j]));
						if (p.zr)
							dv[j] = '0;
						else if (p.ovf[j])
							dv[j] = p.neg[j] ? W'(MINV) : W'(MAXV);
						else
							dv[j] = sat(p.neg[j] ? -qs : qs);
					end
					nxt.res = '0;
					if (p.func) begin
						nxt.res = p.mat;
					end else begin
						for (int j = 0; j < 4; j++) begin
							if (j == int'(p.br)) begin
								nxt.res[j] = half;
							end else begin
								nxt.res[j] = dv[idx];
								idx = idx + 1;
							end
						end
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_sn[k] <= 1'b0;
			end else if (adv[k]) begin
				vld_sn[k] <= src_vld;
			end
		end

		always_ff @(posedge clk) begin
			if (adv[k] && src_vld) begin
				pipe_sn[k] <= nxt;
			end
		end
	end

	assign result_valid = vld_sn[NP-1];
	assign result.out_0 = pipe_sn[NP-1].res[0];
	assign result.out_1 = pipe_sn[NP-1].res[1];
	assign result.out_2 = pipe_sn[NP-1].res[2];
	assign result.out_3 = pipe_sn[NP-1].res[3];
	assign result.out_4 = pipe_sn[NP-1].res[4];
	assign result.out_5 = pipe_sn[NP-1].res[5];
	assign result.out_6 = pipe_sn[NP-1].res[6];
	assign result.out_7 = pipe_sn[NP-1].res[7];
	assign result.out_8 = pipe_sn[NP-1].res[8];

`ifndef SYNTHESIS
	// A blocked result holds its word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// Matrix to quaternion leaves the upper five slots at zero
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !pipe_sn[NP-1].func |->
			result.out_4 == '0 && result.out_5 == '0 && result.out_6 == '0 &&
			result.out_7 == '0 && result.out_8 == '0)
		else $error("nonzero upper slot on matrix to quaternion");

	// The input only stalls when its register is full and cannot move on
	a_istall: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> vld_s1 && vld_sn[0])
		else $error("input stalled with room in the pipeline");
`endif

endmodule
